>>> hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types, constants and the control store for the modular
// exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // field widths
  localparam int unsigned BASE_W  = 63;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned POWER_W = 30;

  // modulus and its barrett constant floor(2^60 / p)
  localparam int unsigned        PRIME_VAL = 32'd1000000007;
  localparam logic [29:0]        PRIME     = 30'(PRIME_VAL);
  localparam logic [31:0]        PRIME_X2  = 32'(2 * PRIME_VAL);
  localparam logic [63:0]        BARRETT_M64 = (64'd1 << 60) / 64'(PRIME_VAL);
  localparam logic [30:0]        BARRETT_M = BARRETT_M64[30:0];

  // control store
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] mexp_step_t;

  localparam mexp_step_t STEP_LOAD     = 4'd0;
  localparam mexp_step_t STEP_FOLD_HI  = 4'd1;
  localparam mexp_step_t STEP_WAIT_HI  = 4'd2;
  localparam mexp_step_t STEP_FOLD_LO  = 4'd3;
  localparam mexp_step_t STEP_WAIT_LO  = 4'd4;
  localparam mexp_step_t STEP_TEST     = 4'd5;
  localparam mexp_step_t STEP_MUL      = 4'd6;
  localparam mexp_step_t STEP_SQR      = 4'd7;
  localparam mexp_step_t STEP_WAIT_BIT = 4'd8;
  localparam mexp_step_t STEP_EMIT     = 4'd9;

  typedef enum logic [1:0] {OP_NONE, OP_FOLD, OP_MUL, OP_SQR} mexp_op_t;
  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_UNIT, HOLD_OUT} mexp_hold_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_ALWAYS, JMP_EXP_ZERO} mexp_jump_t;

  typedef struct packed {
    mexp_op_t   op;
    logic       op_if_bit;  // issue only when exponent lsb is set
    logic       dest_acc;   // result goes to accumulator, else base
    logic       fold_hi;    // fold the top base digits
    logic       load;
    logic       shift;
    logic       emit;
    mexp_hold_t hold;
    mexp_jump_t jump;
    mexp_step_t target;
  } mexp_uword_t;

  // request into the multiply/reduce pipeline
  typedef struct packed {
    logic        valid;
    logic        fold;      // reduce {a, b} instead of a * b
    logic        dest_acc;
    logic [29:0] a;
    logic [29:0] b;
  } mexp_req_t;

  typedef struct packed {
    logic        valid;
    logic        dest_acc;
    logic [29:0] value;
  } mexp_rsp_t;

  function automatic mexp_uword_t ucode(input mexp_step_t step);
    mexp_uword_t w;
    w.op        = OP_NONE;
    w.op_if_bit = 1'b0;
    w.dest_acc  = 1'b0;
    w.fold_hi   = 1'b0;
    w.load      = 1'b0;
    w.shift     = 1'b0;
    w.emit      = 1'b0;
    w.hold      = HOLD_NONE;
    w.jump      = JMP_NEXT;
    w.target    = STEP_LOAD;
    unique case (step)
      STEP_LOAD: begin
        w.hold = HOLD_IN;
        w.load = 1'b1;
      end
      STEP_FOLD_HI: begin
        w.op      = OP_FOLD;
        w.fold_hi = 1'b1;
      end
      STEP_WAIT_HI: w.hold = HOLD_UNIT;
      STEP_FOLD_LO: w.op = OP_FOLD;
      STEP_WAIT_LO: w.hold = HOLD_UNIT;
      STEP_TEST: begin
        w.jump   = JMP_EXP_ZERO;
        w.target = STEP_EMIT;
      end
      STEP_MUL: begin
        w.op        = OP_MUL;
        w.op_if_bit = 1'b1;
        w.dest_acc  = 1'b1;
      end
      STEP_SQR: begin
        w.op    = OP_SQR;
        w.shift = 1'b1;
      end
      STEP_WAIT_BIT: begin
        w.hold   = HOLD_UNIT;
        w.jump   = JMP_ALWAYS;
        w.target = STEP_TEST;
      end
      STEP_EMIT: begin
        w.hold   = HOLD_OUT;
        w.emit   = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = STEP_LOAD;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/mexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mulmod
// Four-stage multiply and barrett reduction modulo 1000000007.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_pkg::mexp_req_t req,
  output mexp_pkg::mexp_rsp_t rsp,
  output logic                busy
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        d1_r, d2_r, d3_r, d4_r;
  logic [59:0] x1_r, x1_nxt;
  logic [31:0] x2_r, x3_r;
  logic [30:0] q2_r;
  logic [31:0] qp3_r;
  logic [29:0] res_r, res_nxt;
  logic [61:0] bq;
  logic [31:0] r0, r1, r2;

  // operand or concatenated digits
  always_comb begin
    if (req.fold) begin
      x1_nxt = {req.a, req.b};
    end else begin
      x1_nxt = 60'(req.a) * 60'(req.b);
    end
  end

  assign bq = 62'(x1_r[59:29]) * 62'(mexp_pkg::BARRETT_M);

  // remainder lies below 3p, so only the low 32 bits matter
  always_comb begin
    r0 = x3_r - qp3_r;
    r1 = r0 - 32'(mexp_pkg::PRIME);
    r2 = r0 - mexp_pkg::PRIME_X2;
    if (r0 >= mexp_pkg::PRIME_X2) begin
      res_nxt = r2[29:0];
    end else if (r0 >= 32'(mexp_pkg::PRIME)) begin
      res_nxt = r1[29:0];
    end else begin
      res_nxt = r0[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= x1_nxt;
    d1_r  <= req.dest_acc;
    q2_r  <= bq[61:31];
    x2_r  <= x1_r[31:0];
    d2_r  <= d1_r;
    qp3_r <= 32'(q2_r) * 32'(mexp_pkg::PRIME);
    x3_r  <= x2_r;
    d3_r  <= d2_r;
    res_r <= res_nxt;
    d4_r  <= d3_r;
  end

  assign rsp.valid    = v4_r;
  assign rsp.dest_acc = d4_r;
  assign rsp.value    = res_r;
  assign busy         = v1_r | v2_r | v3_r | v4_r;

endmodule

>>> hdl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod 1000000007 by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item in, one result out. The base is first folded below the prime in two
// passes through the reduce pipeline, then each exponent bit from the lsb up
// issues a conditional accumulator multiply and a base square back to back
// into a shared four-stage multiply/barrett-reduce pipeline. Each bit waits
// out the pipeline latency before the next begins. A zero exponent gives 1
// for every base. The result sits in an output register, so the next item is
// taken while the last result still waits for its transfer.
module modular_exponentiation_unit (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [62:0] base, [125:63] exponent, rest zero
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // [29:0] power, rest zero
);

  mexp_pkg::mexp_step_t  step_r, step_nxt;
  mexp_pkg::mexp_uword_t uw;
  mexp_pkg::mexp_req_t   req;
  mexp_pkg::mexp_rsp_t   rsp;
  logic                  unit_busy;
  logic                  stall, go, taken;

  logic [62:0]           base_r;     // raw base, kept for the fold passes
  logic [62:0]           exp_r;      // exponent, shifted right one bit per pass
  logic [29:0]           acc_r;      // running product
  logic [29:0]           b_r;        // base power, squared each pass
  logic                  out_valid_r;
  logic [29:0]           out_power_r;

  // control store lookup
  assign uw = mexp_pkg::ucode(step_r);

  // hold decode
  always_comb begin
    unique case (uw.hold)
      mexp_pkg::HOLD_NONE: stall = 1'b0;
      mexp_pkg::HOLD_IN:   stall = !in_tvalid;
      mexp_pkg::HOLD_UNIT: stall = unit_busy;
      mexp_pkg::HOLD_OUT:  stall = out_valid_r && !out_tready;
      default:             stall = 1'b0;
    endcase
  end

  assign go = !stall;

  // jump decode
  always_comb begin
    unique case (uw.jump)
      mexp_pkg::JMP_NEXT:     taken = 1'b0;
      mexp_pkg::JMP_ALWAYS:   taken = 1'b1;
      mexp_pkg::JMP_EXP_ZERO: taken = (exp_r == '0);
      default:                taken = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + mexp_pkg::mexp_step_t'(1);
    end
  end

  // operand selection for the reduce pipeline
  always_comb begin
    req.valid    = go && (uw.op != mexp_pkg::OP_NONE) && (!uw.op_if_bit || exp_r[0]);
    req.fold     = (uw.op == mexp_pkg::OP_FOLD);
    req.dest_acc = uw.dest_acc;
    case (uw.op)
      mexp_pkg::OP_FOLD: begin
        if (uw.fold_hi) begin
          req.a = {27'd0, base_r[62:60]};
          req.b = base_r[59:30];
        end else begin
          req.a = b_r;
          req.b = base_r[29:0];
        end
      end
      mexp_pkg::OP_MUL: begin
        req.a = acc_r;
        req.b = b_r;
      end
      default: begin
        req.a = b_r;
        req.b = b_r;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp),
    .busy  (unit_busy)
  );

  // sequencer and output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= mexp_pkg::STEP_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (go && uw.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (go && uw.load) begin
      base_r <= in_tdata[62:0];
      exp_r  <= in_tdata[125:63];
      acc_r  <= 30'd1;
    end else begin
      if (go && uw.shift) begin
        exp_r <= exp_r >> 1;
      end
      if (rsp.valid) begin
        if (rsp.dest_acc) begin
          acc_r <= rsp.value;
        end else begin
          b_r <= rsp.value;
        end
      end
    end
    if (go && uw.emit) begin
      out_power_r <= acc_r;
    end
  end

  assign in_tready  = (uw.hold == mexp_pkg::HOLD_IN);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'd0, out_power_r};

  // the pipeline is drained before a new item is loaded
  a_no_wb_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid |-> step_r != mexp_pkg::STEP_LOAD)
    else $error("reduce result returned while waiting for input");

  // a result is only emitted once all multiplies have landed
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (go && uw.emit) |-> !unit_busy)
    else $error("result emitted with multiplies in flight");

  // every reduce result is fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid |-> rsp.value < mexp_pkg::PRIME)
    else $error("reduce result not below the prime");

endmodule

>>> bench/modular_exponentiation_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_test
// Self-checking bench for base^exponent mod 1000000007.
// ----------------------------------------------------------------------------
// Drives directed corner items and then a mix of random bases and exponents
// through the input stream, with random gaps on the input and random stalls on
// the result stream, and one pause that lets the unit drain completely. Each
// input transfer queues the power predicted by a square-and-multiply model.
// Every result transfer is checked against the oldest queued power. The last
// part of the run uses no idling on either side.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_test;

  typedef struct {
    logic [mexp_pkg::BASE_W-1:0]  base;
    logic [mexp_pkg::EXP_W-1:0]   exponent;
    logic [mexp_pkg::POWER_W-1:0] power;
  } power_job_t;

  localparam logic [63:0] MODULUS = 64'(mexp_pkg::PRIME_VAL);
  localparam logic [62:0] MAX_63  = {63{1'b1}};

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata   = '0;   // [62:0] base, [125:63] exponent, rest zero
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [31:0]  out_tdata;         // [29:0] power, rest zero

  power_job_t   pending_powers[$];
  logic         idle_en      = 1'b1;
  int           stall_left   = 0;
  int           fail_count   = 0;

  modular_exponentiation_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // square-and-multiply from the top exponent bit down, base reduced first
  function automatic logic [mexp_pkg::POWER_W-1:0] power_mod_prime(
      input logic [62:0] base, input logic [62:0] exponent);
    logic [63:0] reduced;
    logic [63:0] acc;
    reduced = 64'(base) % MODULUS;
    acc     = 64'd1;
    for (int i = int'(mexp_pkg::EXP_W) - 1; i >= 0; i--) begin
      acc = (acc * acc) % MODULUS;
      if (exponent[i]) begin
        acc = (acc * reduced) % MODULUS;
      end
    end
    return acc[mexp_pkg::POWER_W-1:0];
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // one input transfer, with an optional random gap ahead of it
  task automatic send_item(input logic [62:0] base, input logic [62:0] exponent);
    power_job_t job;
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, exponent, base};
    do @(posedge clk); while (!in_tready);
    job.base     = base;
    job.exponent = exponent;
    job.power    = power_mod_prime(base, exponent);
    pending_powers = {pending_powers, job};
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // random exponent, mostly of a random width so that most items stay short
  function automatic logic [62:0] rand_exponent();
    int width;
    if ($urandom_range(0, 3) == 0) begin
      return rand63();
    end
    width = $urandom_range(0, 63);
    return (width == 0) ? '0 : (rand63() >> (63 - width));
  endfunction

  function automatic logic [62:0] rand_base();
    logic [63:0] k;
    case ($urandom_range(0, 5))
      0: return rand63();
      1: return 63'($urandom_range(0, 15));
      2: begin
        k = 64'($urandom);
        return 63'(k * MODULUS);
      end
      3: return 63'(MODULUS - 1 + 64'($urandom_range(0, 2)));
      4: return rand63() >> $urandom_range(0, 62);
      default: return 63'($urandom) % 63'(mexp_pkg::PRIME_VAL);
    endcase
  endfunction

  task automatic test_corner_values();
    send_item('0, '0);
    send_item(63'(MODULUS), '0);
    send_item(MAX_63, '0);
    send_item('0, MAX_63);
    send_item('0, 63'd1);
    send_item(63'd1, MAX_63);
    send_item(63'(MODULUS), 63'd5);
    send_item(63'(2 * MODULUS), MAX_63);
    send_item(63'(MODULUS - 1), 63'd1);
    send_item(63'(MODULUS - 1), 63'd2);
    send_item(63'(MODULUS - 1), MAX_63);
    send_item(63'(MODULUS + 2), 63'd10);
    send_item(63'd2, 63'd1);
    send_item(63'd2, 63'd30);
    send_item(63'd2, 63'd62);
    send_item(MAX_63, 63'd1);
    send_item(MAX_63, MAX_63);
    send_item(63'd3, 63'd1 << 62);
    send_item(63'd1 << 62, 63'd3);
    send_item(63'd10, 63'(MODULUS - 1));     // fermat, gives one
    send_item(63'd10, 63'(MODULUS - 2));     // modular inverse
    send_item(63'h2aaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555);
    send_item(63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_random_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(rand_base(), rand_exponent());
    end
  endtask

  // the input stays quiet until the unit has returned everything
  task automatic test_restart_after_drain();
    test_random_mixed(60);
    wait_for_drain();
    test_random_mixed(60);
  endtask

  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    test_random_mixed(count);
  endtask

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    power_job_t job;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_powers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result transfer: power %0d",
                   out_tdata[mexp_pkg::POWER_W-1:0]);
        end
      end else begin
        job = pending_powers.pop_front();
        if (out_tdata[mexp_pkg::POWER_W-1:0] !== job.power) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("power mismatch: base %0d exponent %0d expected %0d actual %0d",
                     job.base, job.exponent, job.power,
                     out_tdata[mexp_pkg::POWER_W-1:0]);
          end
        end
      end
    end
  end

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_random_mixed(900);
    test_restart_after_drain();
    test_back_to_back(160);
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_powers.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    // room for a stray extra result to show up
    repeat (600) @(posedge clk);
    fail_count += pending_powers.size();
    if (fail_count == 0) begin
      $display("modular_exponentiation_unit_test passed");
    end else begin
      $display("modular_exponentiation_unit_test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("modular_exponentiation_unit_test failed");
    $finish;
  end

endmodule
